FILE: rtl/core/i2c_ras_pkg.sv
// shared types and codes for the i2c register access sequencer
package i2c_ras_pkg;

  // request and event codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_EVENT = 2'd2;

  // bus actions
  localparam logic [2:0] ACT_START     = 3'd0;
  localparam logic [2:0] ACT_SEND      = 3'd1;
  localparam logic [2:0] ACT_RESTART   = 3'd2;
  localparam logic [2:0] ACT_RECV_NACK = 3'd3;
  localparam logic [2:0] ACT_STOP      = 3'd4;

  // completion status
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_ADDR_NACK  = 3'd1;
  localparam logic [2:0] ST_REG_NACK   = 3'd2;
  localparam logic [2:0] ST_DATA_NACK  = 3'd3;
  localparam logic [2:0] ST_RADDR_NACK = 3'd4;

  // sequence phases
  localparam int unsigned PhaseW = 4;
  localparam logic [PhaseW-1:0] PH_IDLE    = 4'd0;
  localparam logic [PhaseW-1:0] PH_START   = 4'd1;
  localparam logic [PhaseW-1:0] PH_WADDR   = 4'd2;
  localparam logic [PhaseW-1:0] PH_REG     = 4'd3;
  localparam logic [PhaseW-1:0] PH_DATA    = 4'd4;
  localparam logic [PhaseW-1:0] PH_RESTART = 4'd5;
  localparam logic [PhaseW-1:0] PH_RADDR   = 4'd6;
  localparam logic [PhaseW-1:0] PH_RDATA   = 4'd7;

  // write direction clears the address low bit
  localparam logic [7:0] ADDR_W_MASK = 8'hFE;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] slave_addr;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       acked;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [2:0] bus_action;
    logic [7:0] bus_byte;
    logic       done_res;
    logic [2:0] status;
    logic [7:0] read_data;
  } result_t;

endpackage

FILE: rtl/core/i2c_ras_seq.sv
// sequence state and single-step transition logic
module i2c_ras_seq import i2c_ras_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  output logic    res_valid_o,
  output result_t res_o
);

  logic [PhaseW-1:0] phase_q, phase_d;
  logic              is_read_q, is_read_d;
  logic [7:0]        slave_q, slave_d;
  logic [7:0]        register_q, register_d;
  logic [7:0]        data_q, data_d;

  // closing stop with a given status
  function automatic result_t stop_res(logic [2:0] st, logic [7:0] rd);
    result_t r;
    r            = '0;
    r.bus_action = ACT_STOP;
    r.done_res   = 1'b1;
    r.status     = st;
    r.read_data  = rd;
    return r;
  endfunction

  always_comb begin
    phase_d     = phase_q;
    is_read_d   = is_read_q;
    slave_d     = slave_q;
    register_d  = register_q;
    data_d      = data_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if ((item_i.cmd == CMD_WRITE) || (item_i.cmd == CMD_READ)) begin
      if (phase_q == PH_IDLE) begin
        slave_d          = item_i.slave_addr;
        register_d       = item_i.reg_addr;
        data_d           = item_i.write_data;
        is_read_d        = (item_i.cmd == CMD_READ);
        phase_d          = PH_START;
        res_valid_o      = 1'b1;
        res_o.bus_action = ACT_START;
      end
    end else if (item_i.cmd == CMD_EVENT) begin
      unique case (phase_q)
        PH_START: begin
          phase_d          = PH_WADDR;
          res_valid_o      = 1'b1;
          res_o.bus_action = ACT_SEND;
          res_o.bus_byte   = slave_q & ADDR_W_MASK;
        end
        PH_WADDR: begin
          res_valid_o = 1'b1;
          if (!item_i.acked) begin
            phase_d = PH_IDLE;
            res_o   = stop_res(ST_ADDR_NACK, 8'd0);
          end else begin
            phase_d          = PH_REG;
            res_o.bus_action = ACT_SEND;
            res_o.bus_byte   = register_q;
          end
        end
        PH_REG: begin
          res_valid_o = 1'b1;
          if (!item_i.acked) begin
            phase_d = PH_IDLE;
            res_o   = stop_res(ST_REG_NACK, 8'd0);
          end else if (is_read_q) begin
            phase_d          = PH_RESTART;
            res_o.bus_action = ACT_RESTART;
          end else begin
            phase_d          = PH_DATA;
            res_o.bus_action = ACT_SEND;
            res_o.bus_byte   = data_q;
          end
        end
        PH_DATA: begin
          res_valid_o = 1'b1;
          phase_d     = PH_IDLE;
          res_o       = stop_res(item_i.acked ? ST_OK : ST_DATA_NACK, 8'd0);
        end
        PH_RESTART: begin
          phase_d          = PH_RADDR;
          res_valid_o      = 1'b1;
          res_o.bus_action = ACT_SEND;
          res_o.bus_byte   = slave_q | 8'h01;
        end
        PH_RADDR: begin
          res_valid_o = 1'b1;
          if (!item_i.acked) begin
            phase_d = PH_IDLE;
            res_o   = stop_res(ST_RADDR_NACK, 8'd0);
          end else begin
            phase_d          = PH_RDATA;
            res_o.bus_action = ACT_RECV_NACK;
          end
        end
        PH_RDATA: begin
          res_valid_o = 1'b1;
          phase_d     = PH_IDLE;
          res_o       = stop_res(ST_OK, item_i.rx_byte);
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      is_read_q  <= 1'b0;
      slave_q    <= 8'd0;
      register_q <= 8'd0;
      data_q     <= 8'd0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      is_read_q  <= is_read_d;
      slave_q    <= slave_d;
      register_q <= register_d;
      data_q     <= data_d;
    end
  end

endmodule

FILE: rtl/core/i2c_register_access_sequencer_core.sv
// top level of the i2c register access sequencer: input register, step logic, result register
//
//  channel  | direction | tuser      | tdata                                         | tlast
//  ---------+-----------+------------+-----------------------------------------------+---------
//  s_axis   | in        | cmd        | slave_addr, reg_addr, write_data, acked, rx   | -
//  m_axis   | out       | bus_action | bus_byte, status, read_data                   | done_res
//
// one transfer in per cycle sustained while m_axis does not stall; a transfer fills the input
// register, and the step that retires it fills the result register, which drives m_axis
// the step logic holds a four-bit phase plus the latched request bytes and updates them only
// when an item leaves the input register
// rst_ni clears the phase to idle, the saved bytes and both valid flags
// an m_axis stall holds the result register; the input register keeps taking transfers
// until it is full, so one item waits in each stage
module i2c_register_access_sequencer_core import i2c_ras_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // slave_addr, reg_addr, write_data, acked, rx_byte, zero pad
  input  logic [1:0]  s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // bus_byte, status, read_data, zero pad
  output logic [2:0]  m_axis_tuser,  // bus_action
  output logic        m_axis_tlast   // done_res
);

  // input register
  logic    in_valid_q;
  item_t   in_item_q;
  item_t   in_item_d;

  // result register
  logic    out_valid_q, out_valid_d;
  result_t out_res_q;

  logic    step;
  logic    res_valid;
  result_t res;

  // unpack the incoming transfer
  always_comb begin
    in_item_d.cmd        = s_axis_tuser;
    in_item_d.slave_addr = s_axis_tdata[7:0];
    in_item_d.reg_addr   = s_axis_tdata[15:8];
    in_item_d.write_data = s_axis_tdata[23:16];
    in_item_d.acked      = s_axis_tdata[24];
    in_item_d.rx_byte    = s_axis_tdata[32:25];
  end

  // an item leaves the input register when the result register is free or draining
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q <= in_item_d;
    end
  end

  i2c_ras_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (in_item_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // items that give no result still retire; the taken result is dropped then
  always_comb begin
    if (step) begin
      out_valid_d = res_valid;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_res_q <= res;
    end
  end

  // pack the outgoing transfer
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.bus_action;
  assign m_axis_tlast  = out_res_q.done_res;
  assign m_axis_tdata  = {5'd0, out_res_q.read_data, out_res_q.status, out_res_q.bus_byte};

endmodule
